@@ hdl/cssv_pkg.sv @@
// Package: shared types, codes and constants of the cooking sequence supervisor.
`timescale 1ns / 1ps

package cssv_pkg;

   // Width of the time base; all stream timer arithmetic wraps at this width
   localparam int TIME_BITS = 32;

   // Configuration port geometry
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Configuration register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_DONE_TEMP    = 2'd0,
      REG_TARGET_FLAME = 2'd1,
      REG_STREAM_PER   = 2'd2,
      REG_NONE         = 2'd3
   } reg_idx_type;

   // Register reset values
   localparam logic signed [23:0] DONE_TEMP_RESET    = 24'sd15000;
   localparam logic signed [23:0] TARGET_FLAME_RESET = 24'sd40000;
   localparam logic [15:0]        STREAM_PER_RESET   = 16'd1000;

   // Command codes
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_HOME    = 3'd1,
      OP_START   = 3'd2,
      OP_STOP    = 3'd3,
      OP_ESTOP   = 3'd4,
      OP_RESET   = 3'd5,
      OP_STATUS  = 3'd6,
      OP_UNKNOWN = 3'd7
   } op_type;

   // Supervisor modes
   typedef enum logic [2:0] {
      MODE_UNINIT  = 3'd0,
      MODE_WAIT    = 3'd1,
      MODE_HOMING  = 3'd2,
      MODE_READY   = 3'd3,
      MODE_COOKING = 3'd4,
      MODE_REMOVAL = 3'd5,
      MODE_DONE    = 3'd6,
      MODE_FAULT   = 3'd7
   } mode_type;

   // Overall status codes
   localparam logic [1:0] STAT_UNINIT  = 2'd0;
   localparam logic [1:0] STAT_RUNNING = 2'd1;
   localparam logic [1:0] STAT_FAULT   = 2'd2;

   // Configuration values seen by the datapath
   typedef struct packed {
      logic signed [23:0] done_temp_fx100;
      logic signed [23:0] target_flame_temp_fx100;
      logic [15:0]        stream_period_ms;
   } cfg_type;

   // One input transaction
   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        status_span_ms;
      logic [31:0]        now_ms;
      logic               z_faulted;
      logic               z_homed;
      logic               z_busy;
      logic               r_faulted;
      logic               ir_valid;
      logic signed [23:0] ir_temp_fx100;
      logic               tc_valid;
      logic signed [23:0] tc_temp_fx100;
   } req_item_type;

   // One result transaction
   typedef struct packed {
      logic [2:0]         mode;
      logic [1:0]         overall_status;
      logic               start_homing;
      logic               start_cooking;
      logic               go_removal;
      logic               emergency_stop;
      logic               reset_faults;
      logic               report_status;
      logic               flame_temp_valid;
      logic signed [23:0] flame_temp_fx100;
   } rsp_item_type;

   // Supervisor state carried from tick to tick
   typedef struct packed {
      mode_type               mode;
      logic                   stream_active;
      logic [TIME_BITS-1:0]   stream_start_ms;
      logic [TIME_BITS-1:0]   stream_length_ms;
      logic [TIME_BITS-1:0]   last_report_ms;
   } sup_state_type;

endpackage

@@ hdl/cssv_channels.sv @@
// Interfaces: valid/ready channels for tick transactions and result transactions.
`timescale 1ns / 1ps

interface cssv_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic [31:0]        status_span_ms;
   logic [31:0]        now_ms;
   logic               z_faulted;
   logic               z_homed;
   logic               z_busy;
   logic               r_faulted;
   logic               ir_valid;
   logic signed [23:0] ir_temp_fx100;
   logic               tc_valid;
   logic signed [23:0] tc_temp_fx100;

   modport source (
      output valid, opcode, status_span_ms, now_ms, z_faulted, z_homed, z_busy,
             r_faulted, ir_valid, ir_temp_fx100, tc_valid, tc_temp_fx100,
      input  ready
   );
   modport sink (
      input  valid, opcode, status_span_ms, now_ms, z_faulted, z_homed, z_busy,
             r_faulted, ir_valid, ir_temp_fx100, tc_valid, tc_temp_fx100,
      output ready
   );
endinterface

interface cssv_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic [1:0]         overall_status;
   logic               start_homing;
   logic               start_cooking;
   logic               go_removal;
   logic               emergency_stop;
   logic               reset_faults;
   logic               report_status;
   logic               flame_temp_valid;
   logic signed [23:0] flame_temp_fx100;

   modport source (
      output valid, mode, overall_status, start_homing, start_cooking, go_removal,
             emergency_stop, reset_faults, report_status, flame_temp_valid,
             flame_temp_fx100,
      input  ready
   );
   modport sink (
      input  valid, mode, overall_status, start_homing, start_cooking, go_removal,
             emergency_stop, reset_faults, report_status, flame_temp_valid,
             flame_temp_fx100,
      output ready
   );
endinterface

@@ hdl/cssv_csr.sv @@
// Module: APB-style configuration registers of the supervisor.
`timescale 1ns / 1ps

module cssv_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cssv_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [cssv_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [cssv_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output cssv_pkg::cfg_type                    cfg
);

   cssv_pkg::cfg_type     cfg_ff, cfg_in;
   cssv_pkg::reg_idx_type reg_idx;
   logic                  wr_en;

   // Word decode of the byte address
   assign reg_idx = cssv_pkg::reg_idx_type'(paddr[3:2]);
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   // Register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            cssv_pkg::REG_DONE_TEMP:    cfg_in.done_temp_fx100 = pwdata[23:0];
            cssv_pkg::REG_TARGET_FLAME: cfg_in.target_flame_temp_fx100 = pwdata[23:0];
            cssv_pkg::REG_STREAM_PER:   cfg_in.stream_period_ms = pwdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.done_temp_fx100         <= cssv_pkg::DONE_TEMP_RESET;
         cfg_ff.target_flame_temp_fx100 <= cssv_pkg::TARGET_FLAME_RESET;
         cfg_ff.stream_period_ms        <= cssv_pkg::STREAM_PER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         cssv_pkg::REG_DONE_TEMP:    prdata = {8'd0, cfg_ff.done_temp_fx100};
         cssv_pkg::REG_TARGET_FLAME: prdata = {8'd0, cfg_ff.target_flame_temp_fx100};
         cssv_pkg::REG_STREAM_PER:   prdata = {16'd0, cfg_ff.stream_period_ms};
         default:                    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/cssv_step.sv @@
// Module: one supervisor tick: command handling, stream timer and mode transitions.
`timescale 1ns / 1ps

module cssv_step (
   input  cssv_pkg::cfg_type       cfg,
   input  cssv_pkg::sup_state_type cur,
   input  cssv_pkg::req_item_type  item,
   output cssv_pkg::sup_state_type nxt,
   output cssv_pkg::rsp_item_type  res
);

   localparam int TB = cssv_pkg::TIME_BITS;

   logic [TB-1:0]      now, dur, period;
   logic [TB-1:0]      since_start, since_report;
   cssv_pkg::mode_type m;
   cssv_pkg::op_type   op;
   logic               s_home, s_cook, s_rem, s_estop, s_rst, s_rep;

   assign now    = TB'(item.now_ms);
   assign dur    = TB'(item.status_span_ms);
   assign period = TB'(cfg.stream_period_ms);
   assign op     = cssv_pkg::op_type'(item.opcode);

   always_comb begin
      nxt     = cur;
      s_home  = 1'b0;
      s_cook  = 1'b0;
      s_rem   = 1'b0;
      s_estop = 1'b0;
      s_rst   = 1'b0;
      s_rep   = 1'b0;

      // First tick leaves the uninitialized mode
      m = (cur.mode == cssv_pkg::MODE_UNINIT) ? cssv_pkg::MODE_WAIT : cur.mode;

      // Command handling
      case (op)
         cssv_pkg::OP_HOME: begin
            if (m == cssv_pkg::MODE_WAIT || m == cssv_pkg::MODE_READY ||
                m == cssv_pkg::MODE_DONE) begin
               s_home = 1'b1;
               m      = cssv_pkg::MODE_HOMING;
            end
         end
         cssv_pkg::OP_START: begin
            if (m == cssv_pkg::MODE_READY && item.z_homed) begin
               s_cook = 1'b1;
               m      = cssv_pkg::MODE_COOKING;
            end
         end
         cssv_pkg::OP_STOP: begin
            if (m == cssv_pkg::MODE_COOKING || m == cssv_pkg::MODE_READY ||
                m == cssv_pkg::MODE_DONE) begin
               s_rem = 1'b1;
               m     = cssv_pkg::MODE_REMOVAL;
            end
         end
         cssv_pkg::OP_ESTOP: begin
            s_estop = 1'b1;
            m       = cssv_pkg::MODE_FAULT;
         end
         cssv_pkg::OP_RESET: begin
            if (m == cssv_pkg::MODE_FAULT || m == cssv_pkg::MODE_DONE) begin
               s_rst             = 1'b1;
               nxt.stream_active = 1'b0;
               m                 = cssv_pkg::MODE_WAIT;
            end
         end
         cssv_pkg::OP_STATUS: begin
            if (dur != '0) begin
               nxt.stream_active    = 1'b1;
               nxt.stream_start_ms  = now;
               nxt.stream_length_ms = dur;
               nxt.last_report_ms   = now - period;
            end else begin
               s_rep = 1'b1;
            end
         end
         default: ;
      endcase

      // Status stream timer, wrapping differences
      since_start  = now - nxt.stream_start_ms;
      since_report = now - nxt.last_report_ms;
      if (nxt.stream_active) begin
         if (since_start >= nxt.stream_length_ms) begin
            nxt.stream_active = 1'b0;
         end else if (since_report >= period) begin
            nxt.last_report_ms = now;
            s_rep              = 1'b1;
         end
      end

      // Mode transitions
      case (m)
         cssv_pkg::MODE_HOMING: begin
            if (item.z_faulted) begin
               s_estop = 1'b1;
               m       = cssv_pkg::MODE_FAULT;
            end else if (item.z_homed && !item.z_busy) begin
               m = cssv_pkg::MODE_READY;
            end
         end
         cssv_pkg::MODE_COOKING: begin
            if (item.r_faulted || item.z_faulted) begin
               s_estop = 1'b1;
               m       = cssv_pkg::MODE_FAULT;
            end else if (item.ir_valid && (item.ir_temp_fx100 >= cfg.done_temp_fx100)) begin
               s_rem = 1'b1;
               m     = cssv_pkg::MODE_REMOVAL;
            end
         end
         cssv_pkg::MODE_REMOVAL: begin
            if (item.z_faulted) begin
               s_estop = 1'b1;
               m       = cssv_pkg::MODE_FAULT;
            end else if (!item.z_busy) begin
               m = cssv_pkg::MODE_DONE;
            end
         end
         default: ;
      endcase

      nxt.mode = m;

      // Result transaction
      res.mode = m;
      if (m == cssv_pkg::MODE_UNINIT) begin
         res.overall_status = cssv_pkg::STAT_UNINIT;
      end else if (m == cssv_pkg::MODE_FAULT) begin
         res.overall_status = cssv_pkg::STAT_FAULT;
      end else begin
         res.overall_status = cssv_pkg::STAT_RUNNING;
      end
      res.start_homing     = s_home;
      res.start_cooking    = s_cook;
      res.go_removal       = s_rem;
      res.emergency_stop   = s_estop;
      res.reset_faults     = s_rst;
      res.report_status    = s_rep;
      res.flame_temp_valid = item.tc_valid;
      res.flame_temp_fx100 = item.tc_valid ? item.tc_temp_fx100 : '0;
   end

endmodule

@@ hdl/cooking_sequence_supervisor_core.sv @@
// Module: top level of the cooking sequence supervisor.
`timescale 1ns / 1ps
// A result appears on rsp once its tick transaction has passed the input register and
// then the step logic into the result register. Throughput: one tick per cycle
// unless rsp stalls; the supervisor state feeds back through one register.
// While a result waits on rsp ready the input register takes one more tick, then req stalls.
// Reset (synchronous, active high) clears both pipeline stages, the mode to uninitialized,
// the stream timer state to zero and the configuration registers to their defaults.

module cooking_sequence_supervisor_core (
   input  logic                               clock,
   input  logic                               reset,
   cssv_req_if.sink                           req_if,
   cssv_rsp_if.source                         rsp_if,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cssv_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [cssv_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [cssv_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   cssv_pkg::cfg_type       cfg;
   cssv_pkg::req_item_type  req_item;
   cssv_pkg::req_item_type  in_item_ff, in_item_in;
   logic                    in_valid_ff, in_valid_in;
   cssv_pkg::rsp_item_type  out_item_ff, out_item_in, step_res;
   logic                    out_valid_ff, out_valid_in;
   cssv_pkg::sup_state_type state_ff, state_in, step_nxt;
   logic                    advance, req_accept;

   cssv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Gather the incoming transaction
   always_comb begin
      req_item.opcode             = req_if.opcode;
      req_item.status_span_ms     = req_if.status_span_ms;
      req_item.now_ms             = req_if.now_ms;
      req_item.z_faulted          = req_if.z_faulted;
      req_item.z_homed            = req_if.z_homed;
      req_item.z_busy             = req_if.z_busy;
      req_item.r_faulted          = req_if.r_faulted;
      req_item.ir_valid           = req_if.ir_valid;
      req_item.ir_temp_fx100      = req_if.ir_temp_fx100;
      req_item.tc_valid           = req_if.tc_valid;
      req_item.tc_temp_fx100      = req_if.tc_temp_fx100;
   end

   // Pipeline handshake
   assign advance       = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_accept    = req_if.valid && req_if.ready;

   cssv_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (step_nxt),
      .res  (step_res)
   );

   // Next values of the stages and the supervisor state
   always_comb begin
      in_item_in   = in_item_ff;
      in_valid_in  = in_valid_ff;
      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
         if (in_valid_ff) begin
            out_item_in = step_res;
            state_in    = step_nxt;
         end
      end
      if (req_accept) begin
         in_item_in  = req_item;
         in_valid_in = 1'b1;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: cssv_pkg::MODE_UNINIT, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // Result channel
   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.mode             = out_item_ff.mode;
   assign rsp_if.overall_status   = out_item_ff.overall_status;
   assign rsp_if.start_homing     = out_item_ff.start_homing;
   assign rsp_if.start_cooking    = out_item_ff.start_cooking;
   assign rsp_if.go_removal       = out_item_ff.go_removal;
   assign rsp_if.emergency_stop   = out_item_ff.emergency_stop;
   assign rsp_if.reset_faults     = out_item_ff.reset_faults;
   assign rsp_if.report_status    = out_item_ff.report_status;
   assign rsp_if.flame_temp_valid = out_item_ff.flame_temp_valid;
   assign rsp_if.flame_temp_fx100 = out_item_ff.flame_temp_fx100;

endmodule
